### rtl/sege_pkg.sv
// Shared constants, control/status structs and a leading-zero helper for the signed gamma encoder.
package sege_pkg;

  localparam int unsigned IN_DATA_W       = 32;  // width of the value field on the input bus
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // take the input transaction
    logic norm_step;   // one normalize step on the code number
    logic emit;        // emit one full byte of the code stream
    logic absorb;      // fold the remaining code bits into the partial byte
    logic flush_emit;  // emit the zero-padded partial byte
  } sege_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_flush;    // input transaction is a flush
    logic norm_done;   // top byte of the code number is nonzero
    logic rem_lt_k;    // remaining code bits do not fill the current byte
    logic pend_any;    // partial byte holds bits
    logic out_free;    // output register can take a byte this cycle
  } sege_stat_t;

  // Leading zeros of a byte (returns 7 for a byte of value one; caller keeps it nonzero)
  function automatic logic [2:0] lz8(input logic [7:0] b);
    logic [2:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found) begin
        if (b[i]) begin
          found = 1'b1;
        end else begin
          n = n + 3'd1;
        end
      end
    end
    return n;
  endfunction

endpackage

### rtl/sege_ctrl.sv
// Controller state machine of the signed gamma encoder.
module sege_ctrl
  import sege_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  sege_stat_t stat,
  output sege_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_NORM  = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_flush ? ST_FLUSH : ST_NORM;
        end
      end
      ST_NORM: begin
        cmd.norm_step = 1'b1;
        if (stat.norm_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.rem_lt_k) begin
          cmd.absorb = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_any) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush_emit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/sege_dp.sv
// Datapath of the signed gamma encoder: mapping, normalize, byte packing, output register.
module sege_dp
  import sege_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_action,
  input  logic [IN_DATA_W-1:0] in_value,
  input  sege_cmd_t            cmd,
  output sege_stat_t           stat,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [BYTE_W-1:0]    out_tdata,
  output logic                 out_tlast
);

  localparam int unsigned ZW = $clog2(VALUE_WIDTH);
  localparam int unsigned WW = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned RW = $clog2(2 * VALUE_WIDTH);

  // Partial byte and its fill count
  logic [6:0]              pend_r,  pend_nxt;
  logic [2:0]              pcnt_r,  pcnt_nxt;
  // Code number (normalized after NORM), zeros still to send, code bits still to send
  logic [VALUE_WIDTH-1:0]  v_r,     v_nxt;
  logic [ZW-1:0]           z_r,     z_nxt;
  logic [RW-1:0]           rem_r,   rem_nxt;
  // Output register
  logic                    ovld_r,  ovld_nxt;
  logic [BYTE_W-1:0]       obyte_r, obyte_nxt;
  logic                    olast_r, olast_nxt;

  // Signed to code number mapping
  logic [VALUE_WIDTH-1:0]  raw;
  logic [VALUE_WIDTH-1:0]  mag;
  logic [VALUE_WIDTH-1:0]  mag_sat;
  logic [VALUE_WIDTH-1:0]  u;

  // Normalize
  logic [BYTE_W-1:0]       top8;
  logic [2:0]              fz;
  logic [WW-1:0]           zsum;
  logic [WW-1:0]           wv;

  // Packing
  logic [3:0]              k;
  logic                    z_ge8;
  logic                    z_ge_k;
  logic [BYTE_W-1:0]       next8;
  logic [15:0]             pack_w;
  logic [15:0]             flush_w;
  logic [15:0]             absorb_w;
  logic [3:0]              rem4;
  logic [3:0]              sh;

  assign raw     = in_value[VALUE_WIDTH-1:0];
  assign mag     = (~raw) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
  // most negative input saturates one step toward zero
  assign mag_sat = mag[VALUE_WIDTH-1] ? {1'b0, {(VALUE_WIDTH-1){1'b1}}} : mag;
  assign u       = raw[VALUE_WIDTH-1] ? {mag_sat[VALUE_WIDTH-2:0], 1'b0}
                                      : {raw[VALUE_WIDTH-2:0], 1'b1};

  assign top8 = v_r[VALUE_WIDTH-1 -: BYTE_W];
  assign fz   = lz8(top8);
  assign zsum = WW'(z_r) + WW'(fz);
  assign wv   = WW'(VALUE_WIDTH) - zsum;

  assign k      = 4'(BYTE_W) - {1'b0, pcnt_r};
  assign z_ge8  = 32'(z_r) >= 32'(BYTE_W);
  assign z_ge_k = 32'(z_r) >= 32'(k);
  assign next8  = z_ge8 ? '0 : (top8 >> z_r[2:0]);
  assign pack_w  = ({9'd0, pend_r} << k) | {8'd0, (next8 >> pcnt_r)};
  assign flush_w = {9'd0, pend_r} << k;
  assign rem4    = rem_r[3:0];
  assign absorb_w = ({9'd0, pend_r} << rem4) | {8'd0, (next8 >> (4'(BYTE_W) - rem4))};
  assign sh      = k - {1'b0, z_r[2:0]};

  assign stat.in_flush  = in_action;
  assign stat.norm_done = |top8;
  assign stat.rem_lt_k  = 32'(rem_r) < 32'(k);
  assign stat.pend_any  = (pcnt_r != 3'd0);
  assign stat.out_free  = !ovld_r || out_tready;

  always_comb begin
    pend_nxt  = pend_r;
    pcnt_nxt  = pcnt_r;
    v_nxt     = v_r;
    z_nxt     = z_r;
    rem_nxt   = rem_r;
    ovld_nxt  = ovld_r && !out_tready;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;

    if (cmd.load) begin
      v_nxt = u;
      z_nxt = '0;
    end

    if (cmd.norm_step) begin
      if (top8 == '0) begin
        v_nxt = v_r << BYTE_W;
        z_nxt = z_r + ZW'(BYTE_W);
      end else begin
        v_nxt   = v_r << fz;
        z_nxt   = ZW'(wv - WW'(1'b1));
        rem_nxt = RW'(wv) + RW'(wv) - RW'(1'b1);
      end
    end

    if (cmd.emit) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = pack_w[BYTE_W-1:0];
      olast_nxt = 32'(rem_r) < (32'(k) + 32'(BYTE_W));
      rem_nxt   = rem_r - RW'(k);
      pend_nxt  = '0;
      pcnt_nxt  = '0;
      if (z_ge_k) begin
        z_nxt = z_r - ZW'(k);
      end else begin
        v_nxt = v_r << sh;
        z_nxt = '0;
      end
    end

    if (cmd.absorb) begin
      pend_nxt = absorb_w[6:0];
      pcnt_nxt = pcnt_r + rem_r[2:0];
    end

    if (cmd.flush_emit) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = flush_w[BYTE_W-1:0];
      olast_nxt = 1'b1;
      pend_nxt  = '0;
      pcnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    z_r     <= z_nxt;
    rem_r   <= rem_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;

endmodule

### rtl/signed_elias_gamma_encoder_unit.sv
// Top level of the signed Elias gamma encoder with MSB-first byte packing.
//
//  channel | direction | payload                          | transaction
//  --------+-----------+----------------------------------+----------------------------
//  in_     | slave     | tuser = action, tdata = value    | one encode or flush item
//  out_    | master    | tdata = out_byte, tlast = last   | one packed byte
//
//  An encode runs an accept step, normalize steps (one byte of the code number per cycle,
//  fewer steps for wide code numbers), one emit step per full byte (up to 8 at
//  VALUE_WIDTH = 32; each waits while the output is stalled) and a final step that folds
//  the leftover bits into the partial byte. A flush runs an accept step and a flush step.
//  The byte emitter sets the rate.
//  Reset is synchronous, active low, and empties the partial byte and the output register.
//  A stalled output holds the byte in its register; the emitter waits for it to drain.
//  The block takes one item at a time; in_tready is high only between items.
module signed_elias_gamma_encoder_unit
  import sege_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // [31:0] value
  input  logic [0:0]           in_tuser,   // [0] action (0 encode, 1 flush)
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BYTE_W-1:0]    out_tdata,  // [7:0] out_byte
  output logic                 out_tlast
);

  sege_cmd_t  cmd;
  sege_stat_t stat;

  // Sequence normalize, emit, absorb and flush steps per transaction
  sege_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Map, normalize and pack bits; hold the output byte
  sege_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_action  (in_tuser[0]),
    .in_value   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A byte that is not the last of its item means more bytes follow: block stays busy
  a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |-> !in_tready)
    else $error("input ready while an item still has bytes to send");

  // Every accepted item occupies the block: the controller leaves idle, so in_tready falls
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an accepted transaction");

  // New bytes only come from the emit or flush steps, never from idle
  a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("output byte appeared while the controller was idle");

endmodule

### bench/signed_elias_gamma_encoder_unit_test.sv
// Testbench for the signed Elias gamma encoder: predicts packed bytes and checks the stream.
`timescale 1ns / 1ps

module signed_elias_gamma_encoder_unit_test
  import sege_pkg::*;
();

  localparam int unsigned VW = VALUE_WIDTH_DEF;

  // Input action codes, as carried on in_tuser
  typedef enum bit {
    ACT_ENCODE = 1'b0,
    ACT_FLUSH  = 1'b1
  } gamma_action_t;

  // One packed byte with its end-of-item marker
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              is_last;
  } gamma_byte_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;
  logic [0:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [BYTE_W-1:0]    out_tdata;
  logic                 out_tlast;

  // Predicted partial byte, mirrors the block's pending state
  logic [6:0]  part_bits  = '0;
  logic [2:0]  part_count = '0;

  gamma_byte_t gamma_bytes_q[$];

  int  err_count     = 0;
  int  items_sent    = 0;
  int  flushes_sent  = 0;
  int  bytes_checked = 0;
  bit  send_idle_on  = 1'b1;
  bit  recv_idle_on  = 1'b1;

  signed_elias_gamma_encoder_unit #(
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop for a hung handshake
  initial begin
    #2ms;
    $display("timeout: %0d bytes still expected", gamma_bytes_q.size());
    $display("signed_elias_gamma_encoder_unit_test: errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // Map the signed value to its positive code number; saturate the most negative value
  function automatic logic [63:0] gamma_code_number(input logic [IN_DATA_W-1:0] raw);
    logic [63:0] mag;
    if (raw[VW-1]) begin
      mag = (64'd1 << VW) - 64'(raw[VW-1:0]);
      if (mag >= (64'd1 << (VW - 1))) mag = (64'd1 << (VW - 1)) - 64'd1;
      return mag << 1;
    end
    return (64'(raw[VW-1:0]) << 1) + 64'd1;
  endfunction

  // Shift one code bit into the partial byte; emit the byte once it is full
  task automatic shift_code_bit(input logic b);
    gamma_byte_t nb;
    if (part_count == 3'd7) begin
      nb.data    = {part_bits, b};
      nb.is_last = 1'b0;
      gamma_bytes_q.push_back(nb);
      part_bits  = '0;
      part_count = '0;
    end else begin
      part_bits  = {part_bits[5:0], b};
      part_count = part_count + 3'd1;
    end
  endtask

  // Work out the bytes one accepted transaction produces and queue them
  task automatic predict_gamma_bytes(input gamma_action_t act, input logic [IN_DATA_W-1:0] val);
    logic [63:0] code;
    int          w;
    int          first_size;
    gamma_byte_t nb;
    first_size = gamma_bytes_q.size();
    if (act == ACT_FLUSH) begin
      if (part_count != 3'd0) begin
        nb.data    = {1'b0, part_bits} << (8 - int'(part_count));
        nb.is_last = 1'b0;
        gamma_bytes_q.push_back(nb);
      end
      part_bits  = '0;
      part_count = '0;
    end else begin
      code = gamma_code_number(val);
      w = 0;
      for (int i = 0; i < 64; i++) begin
        if (code[i]) w = i + 1;
      end
      // w-1 zeros, then the code number MSB first
      for (int i = 2 * w - 2; i >= 0; i--) begin
        shift_code_bit((i < 64) ? code[i] : 1'b0);
      end
    end
    if (gamma_bytes_q.size() > first_size) begin
      nb = gamma_bytes_q.pop_back();
      nb.is_last = 1'b1;
      gamma_bytes_q.push_back(nb);
    end
  endtask

  // Drive one transaction, hold it until accepted, then predict its bytes.
  // Keep in_tvalid high across back-to-back items; drop it only for a gap.
  task automatic send_item(input gamma_action_t act, input logic [IN_DATA_W-1:0] val);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    predict_gamma_bytes(act, val);
    items_sent++;
    if (act == ACT_FLUSH) flushes_sent++;
  endtask

  // Check every accepted byte against the oldest prediction; stall at random
  initial begin : byte_checker
    int          stall_left;
    gamma_byte_t exp_b;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        bytes_checked++;
        if (gamma_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last=%0b", out_tdata, out_tlast));
        end else begin
          exp_b = gamma_bytes_q.pop_front();
          if (out_tdata !== exp_b.data)
            report_mismatch($sformatf("byte %0d: data %02h, predicted %02h",
                                      bytes_checked, out_tdata, exp_b.data));
          if (out_tlast !== exp_b.is_last)
            report_mismatch($sformatf("byte %0d: last %0b, predicted %0b",
                                      bytes_checked, out_tlast, exp_b.is_last));
        end
        stall_left = recv_idle_on ? $urandom_range(0, 4) : 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Random value: mostly narrow magnitudes so short and long codes both show up
  function automatic logic [IN_DATA_W-1:0] random_value();
    logic [IN_DATA_W-1:0] v;
    int                   nbits;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: begin
        nbits = $urandom_range(0, 31);
        v = $urandom() & ((32'd1 << nbits) - 32'd1);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  // Flush right after reset: nothing pending, so no byte may appear
  task automatic test_idle_flush();
    send_item(ACT_FLUSH, 32'h0000_0000);
    send_item(ACT_FLUSH, 32'hFFFF_FFFF);
  endtask

  // Extremes of the value field, including the most negative value that saturates
  task automatic test_value_extremes();
    send_item(ACT_ENCODE, 32'h0000_0000);
    send_item(ACT_FLUSH,  32'h0000_0000);
    send_item(ACT_ENCODE, 32'h7FFF_FFFF);
    send_item(ACT_ENCODE, 32'h8000_0001);
    send_item(ACT_ENCODE, 32'h8000_0000);
    send_item(ACT_ENCODE, 32'hFFFF_FFFF);
    send_item(ACT_ENCODE, 32'h0000_0001);
    send_item(ACT_FLUSH,  32'hFFFF_FFFF);
    send_item(ACT_FLUSH,  32'h0000_0000);
  endtask

  // Single-bit codes fill a byte exactly, then two short codes fill one more byte
  task automatic test_byte_boundary();
    repeat (8) send_item(ACT_ENCODE, 32'h0000_0000);
    send_item(ACT_ENCODE, 32'h0000_0001);
    send_item(ACT_ENCODE, 32'hFFFF_FFFE);
    send_item(ACT_FLUSH,  32'h5555_5555);
  endtask

  task automatic test_random_stream(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 12) send_item(ACT_FLUSH, $urandom());
      else                            send_item(ACT_ENCODE, random_value());
    end
  endtask

  initial begin : main_seq
    int drain_cycles;
    apply_reset();
    test_idle_flush();
    test_value_extremes();
    test_byte_boundary();
    test_random_stream(160);
    // Run back to back with no gaps on either side
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    test_random_stream(80);
    send_idle_on = 1'b1;
    test_random_stream(60);
    send_item(ACT_FLUSH, $urandom());
    @(posedge clk);
    in_tvalid <= 1'b0;
    recv_idle_on = 1'b1;

    drain_cycles = 0;
    while (gamma_bytes_q.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    // Leave room for a trailing item that produced no byte
    repeat (30) @(posedge clk);
    while (gamma_bytes_q.size() != 0) begin
      report_mismatch($sformatf("byte %02h never arrived", gamma_bytes_q[0].data));
      void'(gamma_bytes_q.pop_front());
    end

    $display("covered %0d items (%0d flushes) and %0d packed bytes,", items_sent,
             flushes_sent, bytes_checked);
    $display("with extreme values, saturation, byte boundaries and random stalls");
    if (err_count == 0) begin
      $display("signed_elias_gamma_encoder_unit_test: clean");
    end else begin
      $display("signed_elias_gamma_encoder_unit_test: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/sege_pkg.sv
rtl/sege_ctrl.sv
rtl/sege_dp.sv
rtl/signed_elias_gamma_encoder_unit.sv
bench/signed_elias_gamma_encoder_unit_test.sv
